[design/itda_pkg.sv]
// Shared constants and helpers for the integer to decimal ASCII converter.
package itda_pkg;

	localparam int VALUE_W        = 64;
	localparam int DEF_VALUE_BITS = 64;
	localparam int CHAR_W         = 8;
	localparam int DIGIT_W        = 4;
	localparam int BITS_PER_STEP  = 4;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	// Double-dabble correction: a BCD digit of five or more gets three added
	// before the next left shift.
	function automatic logic [DIGIT_W-1:0] dabble_fix(input logic [DIGIT_W-1:0] d);
		dabble_fix = (d >= 4'd5) ? (d + 4'd3) : d;
	endfunction

endpackage

[design/itda_front.sv]
// Input stage: takes a value, splits it into sign and magnitude, registers it.
module itda_front import itda_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [VALUE_W-1:0]    s_tdata,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic                  push_neg,
	output logic [VALUE_BITS-1:0] push_mag
);

	logic [VALUE_BITS-1:0] raw;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;
	logic                  valid_s1;
	logic                  neg_s1;
	logic [VALUE_BITS-1:0] mag_s1;

	// Bits above VALUE_BITS are ignored; the most negative value negates to
	// itself, which read unsigned is exactly its magnitude.
	assign raw = s_tdata[VALUE_BITS-1:0];
	assign neg = raw[VALUE_BITS-1];
	assign mag = neg ? VALUE_BITS'(~raw + 1'b1) : raw;

	assign s_tready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_neg   = neg_s1;
	assign push_mag   = mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			neg_s1 <= neg;
			mag_s1 <= mag;
		end
	end

endmodule

[design/itda_queue.sv]
// Two-entry queue between the input stage and the conversion engine.
module itda_queue #(
	parameter int WIDTH = 65
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[design/itda_back.sv]
// Conversion engine: double-dabble to BCD, then emits ASCII characters.
module itda_back import itda_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  logic                  pop_neg,
	input  logic [VALUE_BITS-1:0] pop_mag,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [CHAR_W-1:0]     m_tdata,
	output logic                  m_tlast
);

	// Digits of 2^VALUE_BITS, enough for any magnitude.
	localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int STEPS      = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int SH_W       = STEPS * BITS_PER_STEP;
	localparam int CNT_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	state_t            state_q;
	logic              neg_q;
	logic [SH_W-1:0]   shift_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BCD_W-1:0]  bcd_n;
	logic [SH_W-1:0]   shift_n;
	logic [IDX_W-1:0]  top_n;
	logic [DIGIT_W-1:0] cur_digit;
	logic              out_load;

	assign pop_ready = (state_q == ST_IDLE);
	assign out_load  = !m_tvalid || m_tready;
	assign cur_digit = bcd_q[idx_q*DIGIT_W +: DIGIT_W];

	// Four dependent double-dabble steps per cycle; the digits within a step
	// are corrected in parallel.
	always_comb begin
		bcd_n   = bcd_q;
		shift_n = shift_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				bcd_n[d*DIGIT_W +: DIGIT_W] = dabble_fix(bcd_n[d*DIGIT_W +: DIGIT_W]);
			end
			bcd_n   = {bcd_n[BCD_W-2:0], shift_n[SH_W-1]};
			shift_n = shift_n << 1;
		end
	end

	// Position of the most significant nonzero digit; zero keeps one digit.
	always_comb begin
		top_n = '0;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] != '0) begin
				top_n = IDX_W'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
			neg_q    <= 1'b0;
			shift_q  <= '0;
			bcd_q    <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else begin
			// A new character is presented whenever the output register is
			// free and the engine is in an emitting state.
			if (out_load) begin
				m_tvalid <= (state_q == ST_SIGN) || (state_q == ST_DIGIT);
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						neg_q   <= pop_neg;
						// Zero padding sits above the magnitude so it shifts in first.
						shift_q <= SH_W'(pop_mag);
						bcd_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q   <= bcd_n;
					shift_q <= shift_n;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS - 1)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q   <= top_n;
					state_q <= neg_q ? ST_SIGN : ST_DIGIT;
				end
				ST_SIGN: begin
					if (out_load) begin
						m_tdata  <= ASCII_MINUS;
						m_tlast  <= 1'b0;
						state_q  <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (out_load) begin
						m_tdata  <= ASCII_ZERO + CHAR_W'(cur_digit);
						m_tlast  <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pop_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> (state_q == ST_CONV))
		else $error("popped entry did not start a conversion");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata == ASCII_MINUS) |-> !m_tlast)
		else $error("minus sign flagged as last character");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == ASCII_MINUS ||
			(m_tdata >= ASCII_ZERO && m_tdata <= ASCII_NINE)))
		else $error("output character is neither a digit nor a minus sign");

	a_emit_only_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !$rose(m_tvalid))
		else $error("character emitted during conversion");

endmodule

[design/integer_to_decimal_ascii_core.sv]
// Top level of the integer to decimal ASCII converter.
//
// Usage: each transaction on the slave channel (s_tvalid, s_tready, s_tdata)
// carries one two's-complement integer in the low VALUE_BITS bits of
// s_tdata; higher bits are ignored. The master channel (m_tvalid, m_tready,
// m_tdata, m_tlast) returns its decimal text, one ASCII character per
// transaction, most significant digit first, with a leading '-' for negative
// values. m_tlast marks the final character of each number. Zero gives '0'.
// Timing: the input stage registers sign and magnitude, a two-entry queue
// holds pending numbers, and the back end converts with a double-dabble unit
// that shifts in four bits per cycle. A number is converted in full and then
// emitted one character at a time; the back end takes no new number until the
// last character of the current one is in its output register.
// While the back end works, up to three more numbers can be taken in.
// Reset clears all valid flags and the queue; no output appears until a new
// number arrives. When the receiver stalls, the current character holds on
// the master channel and the back end waits; the input keeps accepting until the
// queue and the input register are full.
module integer_to_decimal_ascii_core import itda_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [VALUE_W-1:0] s_tdata,  // [63:0] value
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] m_tdata,   // [7:0] character
	output logic              m_tlast
);

	logic                  push_valid;
	logic                  push_ready;
	logic                  push_neg;
	logic [VALUE_BITS-1:0] push_mag;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [VALUE_BITS:0]   pop_data;

	itda_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_neg  (push_neg),
		.push_mag  (push_mag)
	);

	itda_queue #(
		.WIDTH(VALUE_BITS + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_neg, push_mag}),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	itda_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_neg  (pop_data[VALUE_BITS]),
		.pop_mag  (pop_data[VALUE_BITS-1:0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
